>>> rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, field widths, mode codes and the control/status
// structs that join the scheduler controller and datapath.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int MAX_TASKS_DEF = 8;

	localparam int MODE_W  = 2;
	localparam int PRIO_W  = 8;
	localparam int DELAY_W = 16;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 16;

	localparam logic [PRIO_W-1:0] IDLE_PRIO_RESET = 8'd100;

	localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELAY  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

	typedef struct packed {
		logic load;
		logic create;
		logic start;
		logic tick_inc;
		logic scan_clr;
		logic scan_step;
		logic scan_tick;
		logic dly_apply;
		logic sched;
		logic out_load;
	} pts_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              dly_zero;
		logic              found;
		logic              scan_done;
		logic              out_free;
	} pts_status_t;

endpackage

>>> rtl/pts_ifs.sv
// ----------------------------------------------------------------------------
// pts_ifs
// Valid/ready channels of the scheduler: request channel and result channel.
// ----------------------------------------------------------------------------
interface pts_item_if;
	import pts_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [PRIO_W-1:0] priority_req;
	logic [DELAY_W-1:0] delay_ticks;

	modport source(output valid, output mode, output priority_req, output delay_ticks,
		input ready);
	modport sink(input valid, input mode, input priority_req, input delay_ticks,
		output ready);
endinterface

interface pts_result_if;
	import pts_pkg::*;

	logic               valid;
	logic               ready;
	logic               create_ok;
	logic [SLOT_W-1:0]  created_slot;
	logic               running_valid;
	logic [SLOT_W-1:0]  running_slot;
	logic               switched;
	logic [COUNT_W-1:0] switch_count;
	logic [COUNT_W-1:0] tick_count;

	modport source(output valid, output create_ok, output created_slot,
		output running_valid, output running_slot, output switched,
		output switch_count, output tick_count, input ready);
	modport sink(input valid, input create_ok, input created_slot,
		input running_valid, input running_slot, input switched,
		input switch_count, input tick_count, output ready);
endinterface

>>> rtl/priority_task_scheduler_with_delays.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays
// Hardware task scheduler over MAX_TASKS + 1 slots with tick-based delays.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. Every scheduling
// step walks the task slots one per cycle through the priority and delay
// memories, so the slot count sets the time: create, start and tick each
// make one walk, a delay that takes effect needs a second walk, and a
// create with no free slot or a delay of zero ticks makes no walk. The
// result waits in an output register while the next request is taken.
// After reset slot 0 holds the idle task at the idle priority; writing the
// idle priority register also moves slot 0 at once. Priorities are compared
// as smaller number more urgent, with the lower slot winning a tie.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_delays #(
	parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [pts_pkg::PRIO_W-1:0] cfg_wr_data,
	pts_item_if.sink                   item,
	pts_result_if.source               result
);
	import pts_pkg::*;

	pts_cmd_t    cmd;
	pts_status_t status;

	pts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	pts_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.mode         (item.mode),
		.priority_req (item.priority_req),
		.delay_ticks  (item.delay_ticks),
		.cmd          (cmd),
		.status       (status),
		.result       (result)
	);

endmodule

>>> rtl/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath
// Task slot storage (priority and delay memories, ready bits), the slot
// scan with its running best-choice tracker, scheduler state, counters and
// the result register.
// ----------------------------------------------------------------------------
module pts_datapath #(
	parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pts_pkg::PRIO_W-1:0]   cfg_wr_data,
	input  logic [pts_pkg::MODE_W-1:0]   mode,
	input  logic [pts_pkg::PRIO_W-1:0]   priority_req,
	input  logic [pts_pkg::DELAY_W-1:0]  delay_ticks,
	input  pts_pkg::pts_cmd_t            cmd,
	output pts_pkg::pts_status_t         status,
	pts_result_if.source                 result
);
	import pts_pkg::*;

	localparam int SLOTS = MAX_TASKS + 1;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
	localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(SLOTS - 1);

	logic [PRIO_W-1:0]  prio_mem [SLOTS];
	logic [DELAY_W-1:0] dly_mem  [SLOTS];

	logic [PRIO_W-1:0]  idle_q;
	logic [MODE_W-1:0]  mode_q;
	logic [PRIO_W-1:0]  prio_req_q;
	logic [DELAY_W-1:0] dly_q;
	logic [CNT_W-1:0]   next_free_q;
	logic               started_q;
	logic [IDX_W-1:0]   cur_q;
	logic               cur_valid_q;
	logic [COUNT_W-1:0] switches_q;
	logic [COUNT_W-1:0] ticks_q;
	logic [SLOTS-1:0]   ready_q;
	logic               ok_q;
	logic [IDX_W-1:0]   cslot_q;
	logic               sw_q;
	logic [CNT_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               vld_s1;
	logic [PRIO_W-1:0]  prio_s1;
	logic [DELAY_W-1:0] dly_s1;
	logic               found_q;
	logic [IDX_W-1:0]   best_q;
	logic [PRIO_W-1:0]  best_prio_q;
	logic               out_valid_q;

	logic [IDX_W-1:0]   create_slot;
	logic [PRIO_W-1:0]  cand_prio;
	logic               created;
	logic               delayed;
	logic [DELAY_W-1:0] dly_dec;
	logic               tick_hit;
	logic               wake;
	logic               cand_ready;
	logic               better;
	logic               issue;
	logic               dly_we;
	logic [IDX_W-1:0]   dly_waddr;
	logic [DELAY_W-1:0] dly_wdata;

	assign create_slot = next_free_q[IDX_W-1:0];
	assign cand_prio   = (idx_s1 == '0) ? idle_q : prio_s1;
	assign created     = CNT_W'(idx_s1) < next_free_q;
	assign delayed     = created && !ready_q[idx_s1];
	assign dly_dec     = dly_s1 - 1'b1;
	assign tick_hit    = cmd.scan_tick && vld_s1 && delayed;
	assign wake        = tick_hit && (dly_dec == '0);
	assign cand_ready  = ready_q[idx_s1] || wake;
	assign better      = vld_s1 && cand_ready && (!found_q || cand_prio < best_prio_q);
	assign issue       = cmd.scan_step && (idx_q != SLOTS_C);
	assign dly_we      = tick_hit || cmd.dly_apply;
	assign dly_waddr   = cmd.dly_apply ? best_q : idx_s1;
	assign dly_wdata   = cmd.dly_apply ? dly_q : dly_dec;

	assign status.mode      = mode_q;
	assign status.full      = (next_free_q == SLOTS_C);
	assign status.dly_zero  = (dly_q == '0);
	assign status.found     = found_q;
	assign status.scan_done = vld_s1 && (idx_s1 == LAST_C);
	assign status.out_free  = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= mode;
			prio_req_q <= priority_req;
			dly_q      <= delay_ticks;
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (cmd.create) begin
			prio_mem[create_slot] <= prio_req_q;
		end
		if (dly_we) begin
			dly_mem[dly_waddr] <= dly_wdata;
		end
		if (issue) begin
			prio_s1 <= prio_mem[idx_q[IDX_W-1:0]];
			dly_s1  <= dly_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q      <= IDLE_PRIO_RESET;
			next_free_q <= CNT_W'(1);
			started_q   <= 1'b0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			switches_q  <= '0;
			ticks_q     <= '0;
			ready_q     <= SLOTS'(1);
			ok_q        <= 1'b0;
			cslot_q     <= '0;
			sw_q        <= 1'b0;
			idx_q       <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_prio_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				idle_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				ok_q    <= 1'b0;
				cslot_q <= '0;
				sw_q    <= 1'b0;
			end
			if (cmd.create) begin
				next_free_q          <= next_free_q + 1'b1;
				ready_q[create_slot] <= 1'b1;
				ok_q                 <= 1'b1;
				cslot_q              <= create_slot;
			end
			if (cmd.start) begin
				started_q <= 1'b1;
			end
			if (cmd.tick_inc) begin
				ticks_q <= ticks_q + 1'b1;
			end
			if (cmd.dly_apply) begin
				ready_q[best_q] <= 1'b0;
			end
			if (wake) begin
				ready_q[idx_s1] <= 1'b1;
			end
			if (cmd.scan_clr) begin
				idx_q   <= '0;
				vld_s1  <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (issue) begin
					idx_s1 <= idx_q[IDX_W-1:0];
					vld_s1 <= 1'b1;
					idx_q  <= idx_q + 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
			end
			if (better) begin
				found_q     <= 1'b1;
				best_q      <= idx_s1;
				best_prio_q <= cand_prio;
			end
			if (cmd.sched && started_q) begin
				if (found_q) begin
					if (!(cur_valid_q && cur_q == best_q)) begin
						cur_q       <= best_q;
						cur_valid_q <= 1'b1;
						switches_q  <= switches_q + 1'b1;
						sw_q        <= 1'b1;
					end
				end else if (cur_valid_q) begin
					cur_q       <= '0;
					cur_valid_q <= 1'b0;
					switches_q  <= switches_q + 1'b1;
					sw_q        <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.create_ok     <= ok_q;
			result.created_slot  <= SLOT_W'(cslot_q);
			result.running_valid <= cur_valid_q;
			result.running_slot  <= cur_valid_q ? SLOT_W'(cur_q) : '0;
			result.switched      <= sw_q;
			result.switch_count  <= switches_q;
			result.tick_count    <= ticks_q;
		end
	end

`ifndef ASSERT_OFF
	a_next_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q <= SLOTS_C) && (next_free_q != '0))
		else $error("free slot pointer out of range");

	a_choice_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> started_q)
		else $error("task chosen before kernel start");

	a_switch_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.sched) |-> (sw_q == (switches_q != $past(switches_q))))
		else $error("switch flag disagrees with switch counter");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (idx_s1 <= LAST_C))
		else $error("scan index past last slot");
`endif

endmodule

>>> rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer of the scheduler: takes one request, runs the create, start,
// delay or tick step, drives the slot scans and the scheduling decision,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module pts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  pts_pkg::pts_status_t status,
	output pts_pkg::pts_cmd_t    cmd
);
	import pts_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_FIND  = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_SCHED = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		state_nxt  = state_q;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				case (status.mode)
					MODE_CREATE: begin
						if (status.full) begin
							state_nxt = S_DONE;
						end else begin
							cmd.create   = 1'b1;
							cmd.scan_clr = 1'b1;
							state_nxt    = S_SCAN;
						end
					end
					MODE_START: begin
						cmd.start    = 1'b1;
						cmd.scan_clr = 1'b1;
						state_nxt    = S_SCAN;
					end
					MODE_DELAY: begin
						if (status.dly_zero) begin
							state_nxt = S_DONE;
						end else begin
							cmd.scan_clr = 1'b1;
							state_nxt    = S_FIND;
						end
					end
					MODE_TICK: begin
						cmd.tick_inc = 1'b1;
						cmd.scan_clr = 1'b1;
						state_nxt    = S_SCAN;
					end
					default: begin
						state_nxt = S_DONE;
					end
				endcase
			end
			S_FIND: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_nxt = S_APPLY;
				end
			end
			S_APPLY: begin
				if (status.found) begin
					cmd.dly_apply = 1'b1;
					cmd.scan_clr  = 1'b1;
					state_nxt     = S_SCAN;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.scan_tick = (status.mode == MODE_TICK);
				if (status.scan_done) begin
					state_nxt = S_SCHED;
				end
			end
			S_SCHED: begin
				cmd.sched = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
